/* rtl/ltd_pkg.sv */
// shared types and constants for the limited trial division unit
package ltd_pkg;

  localparam int NUM_W = 32;
  localparam int SQ_W  = NUM_W + 1;
  localparam int CNT_W = $clog2(NUM_W);

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [SQ_W-1:0]  sq_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [1:0]       mode_t;

  localparam mode_t MODE_SQRT = 2'd0;
  localparam mode_t MODE_HALF = 2'd1;
  localparam mode_t MODE_FULL = 2'd2;

  localparam cnt_t CNT_LAST = cnt_t'(NUM_W - 1);

endpackage

/* rtl/ltd_req_if.sv */
// request and result channel interfaces
interface ltd_req_if;
  import ltd_pkg::*;
  logic valid;
  logic ready;
  num_t number;
  modport source(output valid, output number, input ready);
  modport sink(input valid, input number, output ready);
endinterface

interface ltd_rsp_if;
  import ltd_pkg::*;
  logic valid;
  logic ready;
  num_t larger_factor;
  num_t smaller_factor;
  modport source(output valid, output larger_factor, output smaller_factor, input ready);
  modport sink(input valid, input larger_factor, input smaller_factor, output ready);
endinterface

/* rtl/limited_trial_division_unit.sv */
// limited trial division unit: splits a number into its largest divisor pair
//
// One request carries a number n. The unit tries divisors d = 2, 3, ... and
// for each one runs a restoring divider that produces one quotient bit per
// cycle; a trial is a compare, NUM_W divide steps and a decide. The walk
// stops at the first d that divides n, or when d*d > n, or when d passes
// the limit set by limit_mode (0 floor square root, 1 n halved, 2 or 3 n
// itself). A hit gives larger_factor = n / d and smaller_factor = d; no
// hit gives (n, 1); n = 0 gives (0, 0). The unit takes one request at a
// time (req.ready only while idle). The result sits in an output register,
// so a new request is accepted while an earlier result still waits to be
// taken. limit_mode is written through cfg_we / cfg_wdata and must only
// change while idle.
module limited_trial_division_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  ltd_pkg::mode_t      cfg_wdata,
  ltd_req_if.sink             req,
  ltd_rsp_if.source           rsp
);
  import ltd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_NEXT,
    ST_DONE
  } state_t;

  state_t state;
  mode_t  limit_mode;

  // latched request and search state
  num_t number;
  num_t divisor;
  sq_t  square;      // divisor * divisor, kept by increments

  // shared divider registers
  num_t rem;
  num_t quot;        // dividend shifts out, quotient shifts in
  cnt_t cnt;

  // pending result
  num_t res_large;
  num_t res_small;

  // result register
  logic out_valid;
  num_t out_large;
  num_t out_small;
  logic load_out;    // pending result moves into the result register

  // divider step: one restoring subtract
  logic [NUM_W+1:0] diff;
  logic             neg;

  // search stop test
  logic past_limit;
  logic stop;

  assign diff = {1'b0, rem, quot[NUM_W-1]} - {2'b00, divisor};
  assign neg  = diff[NUM_W+1];

  always_comb begin
    case (limit_mode)
      MODE_SQRT: past_limit = 1'b0;              // square test covers it
      MODE_HALF: past_limit = divisor > (number >> 1);
      default:   past_limit = divisor > number;  // number itself
    endcase
  end

  assign stop = (square > {1'b0, number}) || past_limit;

  // result register is free, or is being emptied this cycle
  assign load_out = (state == ST_DONE) && (!out_valid || rsp.ready);

  assign req.ready          = (state == ST_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.larger_factor  = out_large;
  assign rsp.smaller_factor = out_small;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_mode <= MODE_SQRT;
    end else if (cfg_we) begin
      limit_mode <= cfg_wdata;
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            number  <= req.number;
            divisor <= num_t'(2);
            square  <= sq_t'(4);
            if (req.number == '0) begin
              // zero has no divisor pair
              res_large <= '0;
              res_small <= '0;
              state     <= ST_DONE;
            end else begin
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (stop) begin
            // no divisor found: number is prime (or one)
            res_large <= number;
            res_small <= num_t'(1);
            state     <= ST_DONE;
          end else begin
            rem   <= '0;
            quot  <= number;
            cnt   <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (!neg) begin
            rem <= diff[NUM_W-1:0];
          end else begin
            rem <= {rem[NUM_W-2:0], quot[NUM_W-1]};
          end
          quot <= {quot[NUM_W-2:0], ~neg};
          cnt  <= cnt + cnt_t'(1);
          if (cnt == CNT_LAST) begin
            state <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (rem == '0) begin
            // smallest divisor found, cofactor is the larger one
            res_large <= quot;
            res_small <= divisor;
            state     <= ST_DONE;
          end else begin
            divisor <= divisor + num_t'(1);
            square  <= square + {divisor, 1'b1};  // (d+1)^2 = d^2 + 2d + 1
            state   <= ST_CHECK;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            out_large <= res_large;
            out_small <= res_small;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/ltd_checker.sv */
// port-level checks for the limited trial division unit
module ltd_checker (
  input logic         clk,
  input logic         rst,
  input logic         req_valid,
  input logic         req_ready,
  input logic         rsp_valid,
  input logic         rsp_ready,
  input ltd_pkg::num_t rsp_large,
  input ltd_pkg::num_t rsp_small
);
  import ltd_pkg::*;

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_large) && $stable(rsp_small))
    else $error("stalled result changed");

  // busy right after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready right after accept");

  // a zero factor only comes as the pair for zero
  a_zero_pair: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_small == '0) |-> rsp_large == '0)
    else $error("zero smaller factor with nonzero larger");

  // smaller factor never exceeds larger and is nonzero for nonzero results
  a_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_large != '0) |-> (rsp_small != '0) && (rsp_small <= rsp_large))
    else $error("factor pair out of order");

endmodule

bind limited_trial_division_unit ltd_checker u_ltd_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_large (rsp.larger_factor),
  .rsp_small (rsp.smaller_factor)
);

/* test/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench for the limited trial division unit
module testbench;
  import ltd_pkg::*;

  // the unused limit code, which the unit treats like MODE_FULL
  localparam mode_t MODE_SPARE = 2'd3;

  localparam int DIRECTED_ROWS  = 25;
  localparam int RANDOM_PHASES  = 4;
  localparam int PHASE_REQUESTS = 19;
  localparam int IDLE_PERCENT   = 12;
  localparam int STEADY_FIRST   = 40;   // random requests with no random idling on either side
  localparam int STEADY_LAST    = 69;
  localparam int HOLDOFF_AT     = DIRECTED_ROWS + 50;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 100;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    num_t larger;
    num_t smaller;
  } factor_pair_t;

  // one directed request; known marks rows whose answer is typed in
  typedef struct packed {
    mode_t        mode;
    num_t         number;
    logic         known;
    factor_pair_t answer;
  } directed_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  mode_t cfg_wdata;

  ltd_req_if req_ch ();
  ltd_rsp_if rsp_ch ();

  limited_trial_division_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // factor pairs still owed by the unit, oldest first
  factor_pair_t pending_factors [$];
  factor_pair_t oldest_pair;

  mode_t       limit_mode_now;
  logic        steady;
  int          mismatches;
  int          requests_sent;
  int          results_seen;
  int          mode_writes;
  int          holdoff_left;
  logic        held_off;
  int unsigned cycle_count;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // floor square root limit: zero, one, tiny primes, square, extremes of the field
    '{MODE_SQRT, 32'd0,          1'b1, '{32'd0,          32'd0}},
    '{MODE_SQRT, 32'd1,          1'b1, '{32'd1,          32'd1}},
    '{MODE_SQRT, 32'd2,          1'b1, '{32'd2,          32'd1}},
    '{MODE_SQRT, 32'd3,          1'b1, '{32'd3,          32'd1}},
    '{MODE_SQRT, 32'd4,          1'b1, '{32'd2,          32'd2}},
    '{MODE_SQRT, 32'hFFFF_FFFF,  1'b1, '{32'd1431655765, 32'd3}},
    '{MODE_SQRT, 32'hFFFF_FFFE,  1'b1, '{32'h7FFF_FFFF,  32'd2}},
    '{MODE_SQRT, 32'h8000_0000,  1'b1, '{32'h4000_0000,  32'd2}},
    '{MODE_SQRT, 32'd65521,      1'b1, '{32'd65521,      32'd1}},
    '{MODE_SQRT, 32'd1000003,    1'b0, '{32'd0,          32'd0}},
    '{MODE_SQRT, 32'd8633,       1'b0, '{32'd0,          32'd0}},
    // halved limit: small numbers sit right at the limit
    '{MODE_HALF, 32'd0,          1'b1, '{32'd0,          32'd0}},
    '{MODE_HALF, 32'd1,          1'b1, '{32'd1,          32'd1}},
    '{MODE_HALF, 32'd2,          1'b0, '{32'd0,          32'd0}},
    '{MODE_HALF, 32'd3,          1'b0, '{32'd0,          32'd0}},
    '{MODE_HALF, 32'd4,          1'b0, '{32'd0,          32'd0}},
    '{MODE_HALF, 32'h5555_5555,  1'b0, '{32'd0,          32'd0}},
    // number itself as limit
    '{MODE_FULL, 32'd0,          1'b1, '{32'd0,          32'd0}},
    '{MODE_FULL, 32'd1,          1'b1, '{32'd1,          32'd1}},
    '{MODE_FULL, 32'd2,          1'b0, '{32'd0,          32'd0}},
    '{MODE_FULL, 32'd49,         1'b0, '{32'd0,          32'd0}},
    '{MODE_FULL, 32'hAAAA_AAAA,  1'b0, '{32'd0,          32'd0}},
    // unused limit code
    '{MODE_SPARE, 32'd0,         1'b1, '{32'd0,          32'd0}},
    '{MODE_SPARE, 32'd13,        1'b0, '{32'd0,          32'd0}},
    '{MODE_SPARE, 32'hC000_0000, 1'b0, '{32'd0,          32'd0}}
  };

  // clock, 20 ns period
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // every input known from time zero
  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = MODE_SQRT;
    req_ch.valid   = 1'b0;
    req_ch.number  = '0;
    rsp_ch.ready   = 1'b0;
    steady         = 1'b0;
    held_off       = 1'b0;
    holdoff_left   = 0;
    limit_mode_now = MODE_SQRT;
    mismatches     = 0;
    requests_sent  = 0;
    results_seen   = 0;
    mode_writes    = 0;
    cycle_count    = 0;
  end

  // expected factor pair for one number under the given limit mode
  function automatic factor_pair_t split_number(input num_t number, input mode_t mode);
    longint unsigned n;
    longint unsigned root;
    longint unsigned probe;
    longint unsigned limit;
    longint unsigned divisor;
    longint unsigned big;
    factor_pair_t    pair;
    n = number;
    pair = '0;
    // bitwise floor square root, at most 16 result bits for a 32-bit number
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      probe = root | (64'd1 << b);
      if (probe * probe <= n) root = probe;
    end
    case (mode)
      MODE_SQRT: limit = root;
      MODE_HALF: limit = n >> 1;
      default:   limit = n;
    endcase
    if (n != 0) begin
      // smallest divisor is at or below the root, or the number itself
      divisor = n;
      for (longint unsigned t = 2; t <= root; t++) begin
        if (n % t == 0) begin
          divisor = t;
          break;
        end
      end
      if (divisor > limit) divisor = n;
      big = n / divisor;
      if (big < divisor) big = divisor;
      pair.larger  = num_t'(big);
      pair.smaller = num_t'(n / big);
    end
    return pair;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // write limit_mode once the unit has delivered every pending result
  task automatic set_limit_mode(input mode_t mode);
    while (pending_factors.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we <= 1'b0;
    limit_mode_now = mode;
    mode_writes++;
  endtask

  // offer one request, wait for it to be taken, then log its factor pair
  task automatic push_number(input num_t number, input logic known,
                             input factor_pair_t answer);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        req_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    req_ch.valid  <= 1'b1;
    req_ch.number <= number;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_factors.push_back(known ? answer : split_number(number, limit_mode_now));
    requests_sent++;
    @(negedge clk);
  endtask

  // random numbers that the divider loop finishes quickly
  function automatic num_t pick_number();
    int unsigned kind;
    int unsigned prime_ish;
    int unsigned cofactor;
    kind = $urandom_range(99);
    if (kind < 45) begin
      // small factor times a wide cofactor reaches every bit of the field
      prime_ish = $urandom_range(2, 101);
      cofactor  = $urandom_range(0, 32'hFFFF_FFFF / prime_ish);
      return num_t'(prime_ish * cofactor);
    end else if (kind < 75) begin
      // small numbers: primes, squares and the limit edges come up often
      return num_t'($urandom_range(0, 4095));
    end else if (kind < 85) begin
      return num_t'(32'd1 << $urandom_range(0, 31));
    end else begin
      // noise: any even value
      return num_t'($urandom() & 32'hFFFF_FFFE);
    end
  endfunction

  // main sequence: reset, directed table, random phases, drain
  initial begin
    mode_t random_modes [RANDOM_PHASES];
    int    k;
    random_modes = '{MODE_HALF, MODE_SQRT, MODE_SPARE, MODE_FULL};
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // the reset value is written explicitly too
    set_limit_mode(MODE_SQRT);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (directed_rows[r].mode != limit_mode_now) begin
        req_ch.valid <= 1'b0;
        set_limit_mode(directed_rows[r].mode);
      end
      push_number(directed_rows[r].number, directed_rows[r].known,
                  directed_rows[r].answer);
    end

    k = 0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      req_ch.valid <= 1'b0;
      set_limit_mode(random_modes[ph]);
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        steady <= (k >= STEADY_FIRST && k <= STEADY_LAST);
        push_number(pick_number(), 1'b0, '0);
        k++;
      end
    end
    req_ch.valid <= 1'b0;
    steady <= 1'b0;

    // let every owed result come back, then watch for strays
    while (pending_factors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d directed) over %0d limit mode writes, all four codes",
             requests_sent, DIRECTED_ROWS, mode_writes);
    $display("checked %0d results, with one %0d-cycle receiver hold-off", results_seen,
             HOLDOFF_CYCLES);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // result side: random back-pressure, plus one long hold-off while
  // requests keep coming so the output register and the unit both fill up
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      rsp_ch.ready <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (!held_off && results_seen == HOLDOFF_AT) begin
      held_off     <= 1'b1;
      holdoff_left <= HOLDOFF_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // compare each delivered result with the oldest owed factor pair
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (pending_factors.size() == 0) begin
        report_mismatch($sformatf("result %0d / %0d with no request pending",
                                  rsp_ch.larger_factor, rsp_ch.smaller_factor));
      end else begin
        oldest_pair = pending_factors.pop_front();
        if (rsp_ch.larger_factor !== oldest_pair.larger)
          report_mismatch($sformatf("larger_factor %0d, wanted %0d",
                                    rsp_ch.larger_factor, oldest_pair.larger));
        if (rsp_ch.smaller_factor !== oldest_pair.smaller)
          report_mismatch($sformatf("smaller_factor %0d, wanted %0d",
                                    rsp_ch.smaller_factor, oldest_pair.smaller));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               pending_factors.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
